>>> hw/rtl/mrrs_pkg.sv
`timescale 1ns / 1ps

package mrrs_pkg;

  localparam int MAX_ROWS  = 16;
  localparam int MAX_COLS  = 16;
  localparam int ELEM_BITS = 16;

  localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CNT_W     = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;

  // fixed field widths of the stream beats
  localparam int FUNC_W     = 3;
  localparam int IDX_W      = 4;
  localparam int VAL_W      = 16;
  localparam int CFG_W      = 5;
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 4;
  localparam int ACC_W      = 64;
  localparam int OUT_USER_W = 2;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_WRITE  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ALL    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_BORDER = 3'd2;
  localparam logic [FUNC_W-1:0] FN_ROW    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_COL    = 3'd4;
  localparam logic [FUNC_W-1:0] FN_SWAP_R = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SWAP_C = 3'd6;

  // configuration register indexes
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef struct packed {
    logic clr;
    logic start;
    logic mul;
  } acc_ctl_t;

  typedef struct packed {
    logic done;
    logic sat;
  } acc_stat_t;

  // rows in use minus one, with zero acting as one and overflow clamped
  function automatic logic [ROW_W-1:0] rows_m1(input logic [CFG_W-1:0] v);
    logic [ROW_W-1:0] r;
    if (v == '0) r = '0;
    else if (int'(v) > MAX_ROWS) r = ROW_W'(MAX_ROWS - 1);
    else r = ROW_W'(v - CFG_W'(1));
    return r;
  endfunction

  function automatic logic [COL_W-1:0] cols_m1(input logic [CFG_W-1:0] v);
    logic [COL_W-1:0] r;
    if (v == '0) r = '0;
    else if (int'(v) > MAX_COLS) r = COL_W'(MAX_COLS - 1);
    else r = COL_W'(v - CFG_W'(1));
    return r;
  endfunction

  // sign-extend or truncate a written value to the element width
  function automatic logic [ELEM_BITS-1:0] elem_fit(input logic [VAL_W-1:0] v);
    logic signed [31:0] w;
    w = 32'(signed'(v));
    return w[ELEM_BITS-1:0];
  endfunction

endpackage

>>> hw/rtl/matrix_region_reduce_and_swap_unit.sv
`timescale 1ns / 1ps

// Matrix of signed 16-bit elements (16 x 16 storage, shape set by rows_in_use and
// cols_in_use) held in one single-port-write, registered-read RAM. Each input beat
// writes an element, reduces a region (whole matrix, border, one row, one column) by
// a saturating signed 64-bit sum or product, or swaps two rows or columns; each beat
// gives exactly one result beat. One item is processed at a time and in_tready is low
// meanwhile. Cost is set by the RAM read port and the shared accumulator: a sum reads
// each element through the RD, DAT and ACC states, a product waits in ACC on a 32 x 16
// multiplier used twice, then a wide add and a clip step, a swap reads both elements
// of a pair and writes both back, and a write, an unused code or an index error walks no
// elements; every item also passes through entry and the DONE state, staying there while
// the output register still holds an untaken result. A finished result waits in the
// output register while the next item is accepted.
// Elements never written read as undefined.

module matrix_region_reduce_and_swap_unit import mrrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // index_a, index_b, element_value
  input  logic [IN_USER_W-1:0]  in_tuser,   // func, multiply_mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [ACC_W-1:0]      out_tdata,  // total
  output logic [OUT_USER_W-1:0] out_tuser   // index_error, saturated
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_DAT  = 4'd2;
  localparam logic [3:0] S_ACC  = 4'd3;
  localparam logic [3:0] S_SWA  = 4'd4;
  localparam logic [3:0] S_SWB  = 4'd5;
  localparam logic [3:0] S_SWWA = 4'd6;
  localparam logic [3:0] S_SWWB = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]           state_r, state_nxt;
  logic [CFG_W-1:0]     rows_cfg_r, cols_cfg_r;
  logic [FUNC_W-1:0]    func_r, func_nxt;
  logic                 mul_r, mul_nxt;
  logic [IDX_W-1:0]     ia_r, ia_nxt;
  logic [IDX_W-1:0]     ib_r, ib_nxt;
  logic [CNT_W-1:0]     a_r, a_nxt;
  logic [CNT_W-1:0]     b_r, b_nxt;
  logic                 ph_r, ph_nxt;
  logic                 err_r, err_nxt;
  logic                 red_r, red_nxt;
  logic [ELEM_BITS-1:0] tmp_r, tmp_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ACC_W-1:0]     out_total_r, out_total_nxt;
  logic                 out_err_r, out_err_nxt;
  logic                 out_sat_r, out_sat_nxt;

  logic [FUNC_W-1:0]    in_func;
  logic                 in_mul;
  logic [IDX_W-1:0]     in_ia;
  logic [IDX_W-1:0]     in_ib;
  logic [VAL_W-1:0]     in_elem;
  logic                 in_acc;
  logic                 in_err;

  logic [ROW_W-1:0]     rows_m1_w;
  logic [COL_W-1:0]     cols_m1_w;
  logic [ROW_W-1:0]     row_a, row_b;
  logic [COL_W-1:0]     col_a, col_b;
  logic [ADDR_W-1:0]    addr_a, addr_b;
  logic                 inner_last, outer_last;
  logic [CNT_W-1:0]     outer_bound;
  logic [CNT_W-1:0]     a_step, b_step;
  logic                 ph_step, walk_end;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [ELEM_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [ELEM_BITS-1:0] ram_rdata;

  acc_ctl_t             acc_ctl;
  acc_stat_t            acc_stat;
  logic [ACC_W-1:0]     acc_total;
  logic                 load_out;

  assign in_func = in_tuser[2:0];
  assign in_mul  = in_tuser[3];
  assign in_ia   = in_tdata[3:0];
  assign in_ib   = in_tdata[7:4];
  assign in_elem = in_tdata[23:8];

  assign rows_m1_w = rows_m1(rows_cfg_r);
  assign cols_m1_w = cols_m1(cols_cfg_r);

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    unique case (in_func)
      FN_WRITE:  in_err = (in_ia > rows_m1_w) || (in_ib > cols_m1_w);
      FN_ROW:    in_err = (in_ia > rows_m1_w);
      FN_COL:    in_err = (in_ia > cols_m1_w);
      FN_SWAP_R: in_err = (in_ia > rows_m1_w) || (in_ib > rows_m1_w);
      FN_SWAP_C: in_err = (in_ia > cols_m1_w) || (in_ib > cols_m1_w);
      default:   in_err = 1'b0;
    endcase
  end

  // element coordinates for the current walk position
  always_comb begin
    row_a = ROW_W'(a_r);
    col_a = COL_W'(b_r);
    row_b = ROW_W'(a_r);
    col_b = COL_W'(b_r);
    unique case (func_r)
      FN_BORDER: begin
        if (!ph_r) begin
          row_a = ROW_W'(a_r);
          col_a = b_r[0] ? cols_m1_w : '0;
        end else begin
          row_a = b_r[0] ? rows_m1_w : '0;
          col_a = COL_W'(a_r);
        end
      end
      FN_ROW, FN_SWAP_R: begin
        row_a = ROW_W'(ia_r);
        col_a = COL_W'(a_r);
        row_b = ROW_W'(ib_r);
        col_b = COL_W'(a_r);
      end
      FN_COL, FN_SWAP_C: begin
        row_a = ROW_W'(a_r);
        col_a = COL_W'(ia_r);
        row_b = ROW_W'(a_r);
        col_b = COL_W'(ib_r);
      end
      default: begin
        row_a = ROW_W'(a_r);
        col_a = COL_W'(b_r);
      end
    endcase
  end

  assign addr_a = {row_a, col_a};
  assign addr_b = {row_b, col_b};

  // loop bounds and the step to the next walk position
  always_comb begin
    unique case (func_r)
      FN_ALL: begin
        inner_last  = (b_r == CNT_W'(cols_m1_w));
        outer_bound = CNT_W'(rows_m1_w);
      end
      FN_BORDER: begin
        inner_last  = b_r[0];
        outer_bound = ph_r ? (CNT_W'(cols_m1_w) - CNT_W'(1)) : CNT_W'(rows_m1_w);
      end
      FN_ROW, FN_SWAP_R: begin
        inner_last  = 1'b1;
        outer_bound = CNT_W'(cols_m1_w);
      end
      default: begin
        inner_last  = 1'b1;
        outer_bound = CNT_W'(rows_m1_w);
      end
    endcase
    outer_last = (a_r == outer_bound);

    a_step   = a_r;
    b_step   = b_r;
    ph_step  = ph_r;
    walk_end = 1'b0;
    if (!inner_last) begin
      b_step = b_r + CNT_W'(1);
    end else begin
      b_step = '0;
      if (!outer_last) begin
        a_step = a_r + CNT_W'(1);
      end else if ((func_r == FN_BORDER) && !ph_r && (cols_m1_w >= COL_W'(2))) begin
        // move on to the inner columns of the top and bottom rows
        ph_step = 1'b1;
        a_step  = CNT_W'(1);
      end else begin
        walk_end = 1'b1;
      end
    end
  end

  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    func_nxt  = func_r;
    mul_nxt   = mul_r;
    ia_nxt    = ia_r;
    ib_nxt    = ib_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    ph_nxt    = ph_r;
    err_nxt   = err_r;
    red_nxt   = red_r;
    tmp_nxt   = tmp_r;

    acc_ctl.clr   = 1'b0;
    acc_ctl.start = 1'b0;
    acc_ctl.mul   = mul_r;

    ram_we    = 1'b0;
    ram_waddr = addr_a;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = addr_a;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          func_nxt = in_func;
          mul_nxt  = in_mul;
          ia_nxt   = in_ia;
          ib_nxt   = in_ib;
          a_nxt    = '0;
          b_nxt    = '0;
          ph_nxt   = 1'b0;
          err_nxt  = in_err;
          red_nxt  = 1'b0;
          if (in_err) begin
            state_nxt = S_DONE;
          end else begin
            unique case (in_func)
              FN_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = {ROW_W'(in_ia), COL_W'(in_ib)};
                ram_wdata = elem_fit(in_elem);
                state_nxt = S_DONE;
              end
              FN_ALL, FN_BORDER, FN_ROW, FN_COL: begin
                red_nxt     = 1'b1;
                acc_ctl.clr = 1'b1;
                acc_ctl.mul = in_mul;
                state_nxt   = S_RD;
              end
              FN_SWAP_R, FN_SWAP_C: begin
                state_nxt = S_SWA;
              end
              default: begin
                state_nxt = S_DONE;
              end
            endcase
          end
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_DAT;
      end
      S_DAT: begin
        acc_ctl.start = 1'b1;
        state_nxt     = S_ACC;
      end
      S_ACC: begin
        if (acc_stat.done) begin
          a_nxt     = a_step;
          b_nxt     = b_step;
          ph_nxt    = ph_step;
          state_nxt = walk_end ? S_DONE : S_RD;
        end
      end
      S_SWA: begin
        ram_re    = 1'b1;
        state_nxt = S_SWB;
      end
      S_SWB: begin
        // first line's element arrives while the second is read
        ram_re    = 1'b1;
        ram_raddr = addr_b;
        tmp_nxt   = ram_rdata;
        state_nxt = S_SWWA;
      end
      S_SWWA: begin
        ram_we    = 1'b1;
        ram_waddr = addr_a;
        ram_wdata = ram_rdata;
        state_nxt = S_SWWB;
      end
      S_SWWB: begin
        ram_we    = 1'b1;
        ram_waddr = addr_b;
        ram_wdata = tmp_r;
        a_nxt     = a_step;
        b_nxt     = b_step;
        ph_nxt    = ph_step;
        state_nxt = walk_end ? S_DONE : S_SWA;
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register: hold a result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_total_nxt = out_total_r;
    out_err_nxt   = out_err_r;
    out_sat_nxt   = out_sat_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_total_nxt = red_r ? acc_total : '0;
      out_err_nxt   = err_r;
      out_sat_nxt   = red_r && acc_stat.sat;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_cfg_r  <= CFG_W'(MAX_ROWS);
      cols_cfg_r  <= CFG_W'(MAX_COLS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROWS: rows_cfg_r <= cfg_wdata;
          CFG_COLS: cols_cfg_r <= cfg_wdata;
          default:  rows_cfg_r <= rows_cfg_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    mul_r       <= mul_nxt;
    ia_r        <= ia_nxt;
    ib_r        <= ib_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    ph_r        <= ph_nxt;
    err_r       <= err_nxt;
    red_r       <= red_nxt;
    tmp_r       <= tmp_nxt;
    out_total_r <= out_total_nxt;
    out_err_r   <= out_err_nxt;
    out_sat_r   <= out_sat_nxt;
  end

  mrrs_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  mrrs_acc u_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (acc_ctl),
    .elem  (ram_rdata),
    .total (acc_total),
    .stat  (acc_stat)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_total_r;
  assign out_tuser  = {out_sat_r, out_err_r};

endmodule

>>> hw/rtl/mrrs_ram.sv
`timescale 1ns / 1ps

module mrrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/mrrs_acc.sv
`timescale 1ns / 1ps

module mrrs_acc import mrrs_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  acc_ctl_t                    ctl,
  input  logic signed [ELEM_BITS-1:0] elem,
  output logic signed [ACC_W-1:0]     total,
  output acc_stat_t                   stat
);

  localparam int HALF   = ACC_W / 2;
  localparam int PP_W   = HALF + ELEM_BITS;
  localparam int PROD_W = ACC_W + ELEM_BITS;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_LO   = 3'd1;
  localparam logic [2:0] A_HI   = 3'd2;
  localparam logic [2:0] A_SUM  = 3'd3;
  localparam logic [2:0] A_FIN  = 3'd4;

  logic [2:0]           st_r, st_nxt;
  logic                 done_r, done_nxt;
  logic                 sat_r, sat_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [ACC_W-1:0]     ma_r, ma_nxt;
  logic [ELEM_BITS-1:0] mb_r, mb_nxt;
  logic                 neg_r, neg_nxt;
  logic [PP_W-1:0]      pp_lo_r, pp_lo_nxt;
  logic [PP_W-1:0]      pp_hi_r, pp_hi_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;

  logic [ACC_W-1:0]     elem_ext;
  logic [ACC_W-1:0]     sum;
  logic                 add_ovf;
  logic [ACC_W-1:0]     ma;
  logic [ELEM_BITS-1:0] mb;
  logic [HALF-1:0]      mul_op;
  logic [PP_W-1:0]      mul_out;
  logic [PROD_W-1:0]    prod_sum;
  logic                 mul_over;
  logic [ACC_W-1:0]     mul_val;

  assign elem_ext = {{(ACC_W-ELEM_BITS){elem[ELEM_BITS-1]}}, elem};
  assign sum      = acc_r + elem_ext;
  assign add_ovf  = (acc_r[ACC_W-1] == elem_ext[ACC_W-1]) && (sum[ACC_W-1] != acc_r[ACC_W-1]);

  assign ma = acc_r[ACC_W-1] ? (ACC_W'(0) - acc_r) : acc_r;
  assign mb = elem[ELEM_BITS-1] ? (ELEM_BITS'(0) - elem) : elem;

  // one shared 32 x ELEM_BITS multiplier, low half first, then high half
  assign mul_op  = (st_r == A_LO) ? ma_r[HALF-1:0] : ma_r[ACC_W-1:HALF];
  assign mul_out = PP_W'(mul_op) * PP_W'(mb_r);

  assign prod_sum = (PROD_W'(pp_hi_r) << HALF) + PROD_W'(pp_lo_r);

  // clip when the magnitude passes 2^63 - 1, or 2^63 for a negative result
  assign mul_over = neg_r
    ? ((prod_r[PROD_W-1:ACC_W] != '0) || (prod_r[ACC_W-1] && (prod_r[ACC_W-2:0] != '0)))
    : (prod_r[PROD_W-1:ACC_W-1] != '0);
  assign mul_val = neg_r ? (ACC_W'(0) - prod_r[ACC_W-1:0]) : prod_r[ACC_W-1:0];

  always_comb begin
    st_nxt    = st_r;
    done_nxt  = 1'b0;
    sat_nxt   = sat_r;
    acc_nxt   = acc_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    neg_nxt   = neg_r;
    pp_lo_nxt = pp_lo_r;
    pp_hi_nxt = pp_hi_r;
    prod_nxt  = prod_r;
    unique case (st_r)
      A_IDLE: begin
        if (ctl.clr) begin
          acc_nxt = ctl.mul ? ACC_W'(1) : '0;
          sat_nxt = 1'b0;
        end else if (ctl.start) begin
          if (ctl.mul) begin
            ma_nxt  = ma;
            mb_nxt  = mb;
            neg_nxt = acc_r[ACC_W-1] ^ elem[ELEM_BITS-1];
            st_nxt  = A_LO;
          end else begin
            acc_nxt  = add_ovf ? (acc_r[ACC_W-1] ? ACC_MIN : ACC_MAX) : sum;
            sat_nxt  = sat_r | add_ovf;
            done_nxt = 1'b1;
          end
        end
      end
      A_LO: begin
        pp_lo_nxt = mul_out;
        st_nxt    = A_HI;
      end
      A_HI: begin
        pp_hi_nxt = mul_out;
        st_nxt    = A_SUM;
      end
      A_SUM: begin
        prod_nxt = prod_sum;
        st_nxt   = A_FIN;
      end
      A_FIN: begin
        acc_nxt  = mul_over ? (neg_r ? ACC_MIN : ACC_MAX) : mul_val;
        sat_nxt  = sat_r | mul_over;
        done_nxt = 1'b1;
        st_nxt   = A_IDLE;
      end
      default: begin
        st_nxt = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      done_r <= 1'b0;
      sat_r  <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      sat_r  <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    ma_r    <= ma_nxt;
    mb_r    <= mb_nxt;
    neg_r   <= neg_nxt;
    pp_lo_r <= pp_lo_nxt;
    pp_hi_r <= pp_hi_nxt;
    prod_r  <= prod_nxt;
  end

  assign total     = acc_r;
  assign stat.done = done_r;
  assign stat.sat  = sat_r;

endmodule
